/* hw/rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and fixed-point helpers of the congestion window engine.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int MAX_BURST = 32;
  localparam int FRAC_BITS = 8;
  localparam int FIX_W     = 40;
  localparam int DIVD_W    = 32 + 2 * FRAC_BITS;
  localparam int BURST_W   = $clog2(MAX_BURST + 1);

  localparam logic [FIX_W-1:0] FIX_MAX = '1;

  localparam logic [15:0] RST_SEGMENT_SIZE  = 16'd1460;
  localparam logic [31:0] RST_INIT_WINDOW   = 32'd1460;
  localparam logic [31:0] RST_INIT_THRESH   = 32'd65535;
  localparam logic [2:0]  DUP_MAX           = 3'd7;
  localparam logic [2:0]  DUP_ACT           = 3'd3;

  localparam logic       OP_START = 1'b0;
  localparam logic       OP_ACK   = 1'b1;

  localparam logic [1:0] CFG_SEGMENT_SIZE = 2'd0;
  localparam logic [1:0] CFG_INIT_WINDOW  = 2'd1;
  localparam logic [1:0] CFG_INIT_THRESH  = 2'd2;

  typedef enum logic [1:0] {
    KIND_SEND   = 2'd0,
    KIND_RETX   = 2'd1,
    KIND_REPORT = 2'd2
  } kind_t;

  function automatic logic [FIX_W-1:0] sat_fix(input logic [63:0] v);
    logic [FIX_W-1:0] r;
    if (v > 64'(FIX_MAX)) r = FIX_MAX;
    else r = v[FIX_W-1:0];
    return r;
  endfunction

  function automatic logic [FIX_W-1:0] load_fix(input logic [31:0] v);
    logic [63:0] w;
    w = 64'(v) << FRAC_BITS;
    return sat_fix(w);
  endfunction

  function automatic logic [31:0] int_part(input logic [FIX_W-1:0] fx);
    logic [FIX_W-1:0] v;
    logic [31:0]      r;
    v = fx >> FRAC_BITS;
    if (64'(v) > 64'hFFFF_FFFF) r = '1;
    else r = v[31:0];
    return r;
  endfunction

endpackage

/* hw/rtl/tcw_div.sv */
// ----------------------------------------------------------------------------
// tcw_div
// Restoring divider, one quotient bit per cycle, for the avoidance increment.
// ----------------------------------------------------------------------------
module tcw_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tcw_pkg::DIVD_W-1:0] dividend,
  input  logic [tcw_pkg::FIX_W-1:0]  divisor,
  output logic                      done,
  output logic [tcw_pkg::DIVD_W-1:0] quotient
);
  import tcw_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [FIX_W-1:0]  rem_r, rem_nxt;
  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [FIX_W-1:0]  div_r, div_nxt;
  logic [FIX_W:0]    trial;
  logic [FIX_W:0]    diff;
  logic              take;

  assign trial = {rem_r, quo_r[DIVD_W-1]};
  assign take  = (trial >= {1'b0, div_r});
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIVD_W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = take ? diff[FIX_W-1:0] : trial[FIX_W-1:0];
      quo_nxt = {quo_r[DIVD_W-2:0], take};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* hw/rtl/tcp_congestion_window_control.sv */
// ----------------------------------------------------------------------------
// tcp_congestion_window_control
// Reno-style sender congestion window engine with send, retransmit and report
// results.
// ----------------------------------------------------------------------------
// One item at a time: in_tready is high only while the engine is idle. An
// old or plain duplicate ACK gives only a report; a start gives a send and
// a report, a third duplicate a retransmit and a report, and a slow-start
// or avoidance ACK N sends and a report, where N (at most MAX_BURST) is the
// number of sends, one output transfer per cycle when out_tready stays high.
// An avoidance ACK first waits on the serial divider, one quotient bit per
// cycle over 48 bits. A stalled output adds its stall cycles.
// ----------------------------------------------------------------------------
module tcp_congestion_window_control (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] ack_number
  input  logic [0:0]  in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [31:0] sequence_res, [63:32] window_bytes,
                                  // [95:64] threshold_bytes
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_BURST,
    S_RETX,
    S_REPORT
  } state_t;

  state_t             state_r, state_nxt;
  logic [15:0]        mss_r;
  logic [31:0]        init_win_r;
  logic [31:0]        init_thr_r;
  logic [FIX_W-1:0]   window_r, window_nxt;
  logic [FIX_W-1:0]   thresh_r, thresh_nxt;
  logic [31:0]        highest_r, highest_nxt;
  logic [31:0]        next_seq_r, next_seq_nxt;
  logic [2:0]         dup_r, dup_nxt;
  logic [BURST_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]        sq_r, sq_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_kind_r, out_kind_nxt;
  logic [31:0]        out_seq_r, out_seq_nxt;
  logic [31:0]        out_win_r, out_win_nxt;
  logic [31:0]        out_thr_r, out_thr_nxt;
  logic               out_last_r, out_last_nxt;

  logic               slot_free;
  logic               in_xfer;
  logic [31:0]        ack;
  logic [63:0]        mss_fx;
  logic [31:0]        inflight;
  logic [63:0]        need;
  logic               fits;
  logic [2:0]         dup_inc;
  logic [FIX_W-1:0]   half;
  logic               div_start;
  logic               div_done;
  logic [DIVD_W-1:0]  div_quo;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = rst_n && (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign ack       = in_tdata;
  assign mss_fx    = 64'(mss_r) << FRAC_BITS;
  assign inflight  = next_seq_r - highest_r;
  assign need      = (64'(inflight) + 64'(mss_r)) << FRAC_BITS;
  assign fits      = !(need > 64'(window_r));
  assign dup_inc   = (dup_r == DUP_MAX) ? DUP_MAX : dup_r + 3'd1;
  assign half      = (64'(window_r >> 1) < mss_fx) ? sat_fix(mss_fx) : (window_r >> 1);
  assign div_start = (state_r == S_DIV_GO);

  tcw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DIVD_W'(sq_r) << (2 * FRAC_BITS)),
    .divisor  (window_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    window_nxt    = window_r;
    thresh_nxt    = thresh_r;
    highest_nxt   = highest_r;
    next_seq_nxt  = next_seq_r;
    dup_nxt       = dup_r;
    cnt_nxt       = cnt_r;
    sq_nxt        = sq_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_seq_nxt   = out_seq_r;
    out_win_nxt   = int_part(window_r);
    out_thr_nxt   = int_part(thresh_r);
    out_last_nxt  = out_last_r;
    if (!slot_free) begin
      out_win_nxt = out_win_r;
      out_thr_nxt = out_thr_r;
    end
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_xfer) begin
          if (in_tuser[0] == OP_START) begin
            window_nxt   = load_fix(init_win_r);
            thresh_nxt   = load_fix(init_thr_r);
            highest_nxt  = '0;
            dup_nxt      = '0;
            next_seq_nxt = '0;
            state_nxt    = S_START;
          end else if (ack > highest_r) begin
            highest_nxt = ack;
            dup_nxt     = '0;
            if (window_r < thresh_r) begin
              window_nxt = sat_fix(64'(window_r) + mss_fx);
              state_nxt  = S_BURST;
            end else if (window_r == '0) begin
              window_nxt = FIX_MAX;
              state_nxt  = S_BURST;
            end else begin
              state_nxt = S_MUL;
            end
          end else if (ack == highest_r) begin
            dup_nxt = dup_inc;
            if (dup_inc == DUP_ACT) begin
              thresh_nxt = half;
              window_nxt = half;
              state_nxt  = S_RETX;
            end else begin
              state_nxt = S_REPORT;
            end
          end else begin
            state_nxt = S_REPORT;
          end
        end
      end
      S_START: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_SEND;
          out_seq_nxt   = '0;
          out_last_nxt  = 1'b0;
          next_seq_nxt  = 32'(mss_r);
          state_nxt     = S_REPORT;
        end
      end
      S_MUL: begin
        sq_nxt    = mss_r * mss_r;
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          window_nxt = sat_fix(64'(window_r) + 64'(div_quo));
          state_nxt  = S_BURST;
        end
      end
      S_BURST: begin
        if (cnt_r == BURST_W'(MAX_BURST) || !fits) begin
          state_nxt = S_REPORT;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_SEND;
          out_seq_nxt   = next_seq_r;
          out_last_nxt  = 1'b0;
          next_seq_nxt  = next_seq_r + 32'(mss_r);
          cnt_nxt       = cnt_r + BURST_W'(1);
        end
      end
      S_RETX: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_RETX;
          out_seq_nxt   = highest_r;
          out_last_nxt  = 1'b0;
          state_nxt     = S_REPORT;
        end
      end
      S_REPORT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_REPORT;
          out_seq_nxt   = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mss_r       <= RST_SEGMENT_SIZE;
      init_win_r  <= RST_INIT_WINDOW;
      init_thr_r  <= RST_INIT_THRESH;
      window_r    <= load_fix(32'(RST_SEGMENT_SIZE));
      thresh_r    <= load_fix(RST_INIT_THRESH);
      highest_r   <= '0;
      next_seq_r  <= '0;
      dup_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      window_r    <= window_nxt;
      thresh_r    <= thresh_nxt;
      highest_r   <= highest_nxt;
      next_seq_r  <= next_seq_nxt;
      dup_r       <= dup_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SEGMENT_SIZE: mss_r      <= cfg_wdata[15:0];
          CFG_INIT_WINDOW:  init_win_r <= cfg_wdata;
          CFG_INIT_THRESH:  init_thr_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    cnt_r      <= cnt_nxt;
    sq_r       <= sq_nxt;
    out_kind_r <= out_kind_nxt;
    out_seq_r  <= out_seq_nxt;
    out_win_r  <= out_win_nxt;
    out_thr_r  <= out_thr_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_thr_r, out_win_r, out_seq_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule
